// ----- src/srrw_pkg.sv -----
// shared constants and types for the selective repeat receive window
// no dependencies; imported by srrw_ctrl, srrw_dp and the top level
package srrw_pkg;

	localparam int SEQ_SPACE = 16;
	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int STEP_W    = SEQ_W + 1;
	localparam int OP_W      = 3;
	localparam int WIN_W     = 4;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5);

	// packet types; codes above OP_OTHER behave as OP_OTHER
	localparam logic [OP_W-1:0] OP_CONNECT = OP_W'(0);
	localparam logic [OP_W-1:0] OP_DATA    = OP_W'(1);
	localparam logic [OP_W-1:0] OP_FINISH  = OP_W'(2);
	localparam logic [OP_W-1:0] OP_ACK     = OP_W'(3);
	localparam logic [OP_W-1:0] OP_OTHER   = OP_W'(4);

	typedef struct packed {
		logic capture;
		logic search;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

// ----- src/selective_repeat_receive_window.sv -----
// channel   | signals                                  | transaction when
// in        | in_valid, in_ready, op, seq              | in_valid && in_ready
// out       | out_valid, out_ready, ack_valid,         | out_valid && out_ready
//           |   ack_seq, link_open                     |
// config    | cfg_we, cfg_wdata (window size)          | cfg_we
//
// one packet at a time, in the steps accept, search and commit;
// the commit waits while a previous result is held in the output register.
// the search is a rotate of the 16-bit bitmap plus a find-first-empty scan.
// reset clears link, closing, expected number and bitmap at once; window resets to 5.
// a new packet is taken while the last result still waits in the output register.
// depends on srrw_pkg, srrw_ctrl, srrw_dp
module selective_repeat_receive_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srrw_pkg::WIN_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [srrw_pkg::OP_W-1:0]     op,
	input  logic [srrw_pkg::SEQ_W-1:0]    seq,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ack_valid,
	output logic [srrw_pkg::SEQ_W-1:0]    ack_seq,
	output logic                          link_open
);
	import srrw_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	srrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	srrw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (op),
		.seq       (seq),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ack_valid (ack_valid),
		.ack_seq   (ack_seq),
		.link_open (link_open)
	);

endmodule

// ----- src/srrw_ctrl.sv -----
// controller state machine for the receive window: sequences capture, search, commit
// depends on srrw_pkg
module srrw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  srrw_pkg::dp_status_t status,
	output srrw_pkg::ctrl_cmd_t  cmd
);
	import srrw_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready    = in_ready_q;
	assign cmd.capture = in_valid && in_ready_q;
	assign cmd.search  = (state_q == S_SEARCH);
	// hold the result back while the output register is still occupied
	assign cmd.commit  = (state_q == S_COMMIT) && !status.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_SEARCH;
						in_ready_q <= 1'b0;
					end
				end
				S_SEARCH: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (!status.out_busy) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("in_ready high outside idle");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.search, cmd.commit}))
		else $error("more than one datapath command at once");

endmodule

// ----- src/srrw_dp.sv -----
// datapath of the receive window: link state, expected number, buffered bitmap,
// rotate and find-first-empty search, output register; depends on srrw_pkg
module srrw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srrw_pkg::ctrl_cmd_t           cmd,
	output srrw_pkg::dp_status_t          status,
	input  logic                          cfg_we,
	input  logic [srrw_pkg::WIN_W-1:0]    cfg_wdata,
	input  logic [srrw_pkg::OP_W-1:0]     op,
	input  logic [srrw_pkg::SEQ_W-1:0]    seq,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ack_valid,
	output logic [srrw_pkg::SEQ_W-1:0]    ack_seq,
	output logic                          link_open
);
	import srrw_pkg::*;

	// architectural state
	logic [WIN_W-1:0]     window_q;
	logic                 link_up_q;
	logic                 closing_q;
	logic [SEQ_W-1:0]     expected_q;
	logic [SEQ_SPACE-1:0] bits_q;

	// captured transaction
	logic [OP_W-1:0]      op_q;
	logic [SEQ_W-1:0]     seq_q;

	// search stage
	logic                 adv_s1;
	logic                 set_s1;
	logic                 ack_s1;
	logic                 link_s1;
	logic                 closing_s1;
	logic [SEQ_W-1:0]     pos_s1;
	logic [SEQ_W-1:0]     seq_s1;
	logic [STEP_W-1:0]    step_s1;

	// output register
	logic                 out_valid_q;
	logic                 ack_valid_q;
	logic [SEQ_W-1:0]     ack_seq_q;
	logic                 link_open_q;

	// decode
	logic                 adv_d;
	logic                 set_d;
	logic                 ack_d;
	logic                 link_d;
	logic                 closing_d;
	logic [SEQ_W-1:0]     pos_d;
	logic [SEQ_W-1:0]     dist_d;
	logic                 in_window_d;
	logic [2*SEQ_SPACE-1:0] rot_wide;
	logic [SEQ_SPACE-1:0] rot_d;
	logic [STEP_W-1:0]    step_d;

	// commit
	logic [SEQ_SPACE-1:0]   run_mask;
	logic [2*SEQ_SPACE-1:0] clr_wide;
	logic [SEQ_SPACE-1:0]   clr_mask;
	logic [SEQ_SPACE-1:0]   set_mask;
	logic [SEQ_W-1:0]       expected_n;

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign ack_valid = ack_valid_q;
	assign ack_seq   = ack_seq_q;
	assign link_open = link_open_q;

	assign dist_d      = seq_q - expected_q;
	assign in_window_d = (dist_d < window_q);

	always_comb begin
		adv_d     = 1'b0;
		set_d     = 1'b0;
		ack_d     = 1'b0;
		link_d    = link_up_q;
		closing_d = closing_q;
		pos_d     = expected_q;
		if (op_q == OP_CONNECT) begin
			if (!link_up_q && !closing_q) begin
				pos_d  = seq_q;
				adv_d  = 1'b1;
				link_d = 1'b1;
				ack_d  = 1'b1;
			end
		end else if (link_up_q) begin
			ack_d = 1'b1;
			unique case (op_q) inside
				OP_DATA, OP_FINISH: begin
					if (op_q == OP_FINISH) begin
						closing_d = 1'b1;
					end
					if (seq_q == expected_q) begin
						adv_d = 1'b1;
					end else if (in_window_d) begin
						set_d = 1'b1;
					end
				end
				OP_ACK: begin
					if (closing_q && (seq_q == expected_q)) begin
						closing_d = 1'b0;
						link_d    = 1'b0;
						ack_d     = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// rotate so the in-order slot sits at bit 0, then find the first empty successor
	assign rot_wide = {bits_q, bits_q} >> pos_d;
	assign rot_d    = rot_wide[SEQ_SPACE-1:0];

	always_comb begin
		step_d = STEP_W'(SEQ_SPACE);
		for (int i = SEQ_SPACE - 1; i >= 1; i--) begin
			if (!rot_d[i]) begin
				step_d = STEP_W'(i);
			end
		end
	end

	// clear the in-order slot and the run of buffered successors
	always_comb begin
		for (int i = 0; i < SEQ_SPACE; i++) begin
			run_mask[i] = (STEP_W'(i) < step_s1);
		end
	end

	assign clr_wide   = {run_mask, run_mask} << pos_s1;
	assign clr_mask   = adv_s1 ? clr_wide[2*SEQ_SPACE-1:SEQ_SPACE] : '0;
	assign set_mask   = set_s1 ? (SEQ_SPACE'(1) << seq_s1) : '0;
	assign expected_n = adv_s1 ? (pos_s1 + step_s1[SEQ_W-1:0]) : expected_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_RESET;
			link_up_q   <= 1'b0;
			closing_q   <= 1'b0;
			expected_q  <= '0;
			bits_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				link_up_q   <= link_s1;
				closing_q   <= closing_s1;
				expected_q  <= expected_n;
				bits_q      <= (bits_q & ~clr_mask) | set_mask;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			seq_q <= seq;
		end
		if (cmd.search) begin
			adv_s1     <= adv_d;
			set_s1     <= set_d;
			ack_s1     <= ack_d;
			link_s1    <= link_d;
			closing_s1 <= closing_d;
			pos_s1     <= pos_d;
			seq_s1     <= seq_q;
			step_s1    <= step_d;
		end
		if (cmd.commit) begin
			ack_valid_q <= ack_s1;
			ack_seq_q   <= ack_s1 ? expected_n : '0;
			link_open_q <= link_s1;
		end
	end

	a_closing_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		closing_q |-> link_up_q)
		else $error("closing flag set while link down");

	a_expected_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!bits_q[expected_q])
		else $error("expected slot marked as buffered");

	a_no_ack_zero_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ack_valid_q || (ack_seq_q == '0)))
		else $error("ack number nonzero without ack");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result written over a pending one");

endmodule

// ----- bench/selective_repeat_receive_window_tb.sv -----
// self-checking bench for selective_repeat_receive_window: directed packets, then random
// sessions under several window settings and idle mixes, checked against a local predictor
// depends on srrw_pkg and the selective_repeat_receive_window rtl
module selective_repeat_receive_window_tb;
	import srrw_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 11;
	localparam int PHASES = 8;
	localparam int PACKETS_PER_PHASE = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [WIN_W-1:0] WIN_MAX = {WIN_W{1'b1}};

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SEQ_W-1:0] seq;
	} packet_t;

	typedef struct packed {
		logic                 link;
		logic                 closing;
		logic [SEQ_W-1:0]     next_seq;
		logic [SEQ_SPACE-1:0] held;
		logic [WIN_W-1:0]     win;
	} window_state_t;

	typedef struct packed {
		logic             ack_valid;
		logic [SEQ_W-1:0] ack_seq;
		logic             link_open;
	} ack_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [WIN_W-1:0] cfg_wdata = WIN_RESET;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [OP_W-1:0]  op = OP_CONNECT;
	logic [SEQ_W-1:0] seq = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             ack_valid;
	logic [SEQ_W-1:0] ack_seq;
	logic             link_open;

	selective_repeat_receive_window uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.seq       (seq),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ack_valid (ack_valid),
		.ack_seq   (ack_seq),
		.link_open (link_open)
	);

	always #(CLK_HALF) clk = ~clk;

	packet_t       pending_pkts[$];
	ack_result_t   acks_due[$];
	window_state_t live_st;
	window_state_t gen_st;
	packet_t       next_pkt;
	packet_t       taken_pkt;
	ack_result_t   predicted;
	ack_result_t   want;
	int            unaccepted_n = 0;
	int            queued_effective = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            mismatch_n = 0;
	int            packets_taken = 0;
	int            results_seen = 0;
	int            acks_seen = 0;
	int            settings_n = 1;
	int            stall_cycles = 0;
	int            win_plan[PHASES] = '{5, 1, 15, 0, 7, 15, 1, 0};

	// in-order arrival: clear the slot, then walk past every buffered successor
	function automatic void slide_past_buffered(inout window_state_t st);
		logic [SEQ_W-1:0] pos;
		logic             walking;
		pos = st.next_seq;
		st.held[pos] = 1'b0;
		walking = 1'b1;
		for (int k = 0; k < SEQ_SPACE; k++) begin
			if (walking) begin
				pos = pos + 1'b1;
				if (st.held[pos]) st.held[pos] = 1'b0;
				else walking = 1'b0;
			end
		end
		st.next_seq = pos;
	endfunction

	function automatic void take_in_data(inout window_state_t st, input logic [SEQ_W-1:0] s);
		logic [SEQ_W-1:0] offset;
		offset = s - st.next_seq;
		if (s == st.next_seq) slide_past_buffered(st);
		else if (offset < st.win) st.held[s] = 1'b1;
	endfunction

	function automatic ack_result_t apply_packet(inout window_state_t st, input packet_t pkt);
		ack_result_t r;
		logic        ack;
		ack = 1'b0;
		if (pkt.op == OP_CONNECT) begin
			if (!st.link && !st.closing) begin
				st.next_seq = pkt.seq;
				st.link = 1'b1;
				slide_past_buffered(st);
				ack = 1'b1;
			end
		end else if (st.link) begin
			ack = 1'b1;
			case (pkt.op)
				OP_DATA: take_in_data(st, pkt.seq);
				OP_FINISH: begin
					st.closing = 1'b1;
					take_in_data(st, pkt.seq);
				end
				OP_ACK: begin
					if (st.closing && pkt.seq == st.next_seq) begin
						st.closing = 1'b0;
						st.link = 1'b0;
						ack = 1'b0;
					end
				end
				default: ;
			endcase
		end
		r.ack_valid = ack;
		r.ack_seq = ack ? st.next_seq : '0;
		r.link_open = st.link;
		return r;
	endfunction

	// queue a packet and run it through the generator's own copy of the window
	task automatic push_packet(input logic [OP_W-1:0] o, input logic [SEQ_W-1:0] s);
		window_state_t prior;
		ack_result_t   r;
		packet_t       pkt;
		pkt.op = o;
		pkt.seq = s;
		prior = gen_st;
		r = apply_packet(gen_st, pkt);
		if (r.ack_valid || prior != gen_st) queued_effective++;
		pending_pkts = {pending_pkts, pkt};
		unaccepted_n++;
	endtask

	task automatic wait_drained();
		while (unaccepted_n != 0 || acks_due.size() != 0) @(posedge clk);
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_n++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_CONNECT;
			seq <= '0;
		end else begin
			if (in_valid && in_ready) begin
				taken_pkt.op = op;
				taken_pkt.seq = seq;
				predicted = apply_packet(live_st, taken_pkt);
				acks_due = {acks_due, predicted};
				unaccepted_n--;
				packets_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_pkts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pkt = pending_pkts.pop_front();
					in_valid <= 1'b1;
					op <= next_pkt.op;
					seq <= next_pkt.seq;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (acks_due.size() == 0) begin
					report_mismatch($sformatf("result ack_valid %0d ack_seq %0d with no packet pending",
						ack_valid, ack_seq));
				end else begin
					want = acks_due.pop_front();
					if (ack_valid !== want.ack_valid)
						report_mismatch($sformatf("ack_valid got %0d expected %0d",
							ack_valid, want.ack_valid));
					if (ack_seq !== want.ack_seq)
						report_mismatch($sformatf("ack_seq got %0d expected %0d",
							ack_seq, want.ack_seq));
					if (link_open !== want.link_open)
						report_mismatch($sformatf("link_open got %0d expected %0d",
							link_open, want.link_open));
					if (want.ack_valid) acks_seen++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: cycles with work pending and no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(unaccepted_n == 0 && acks_due.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d packets and %0d results outstanding",
				unaccepted_n, acks_due.size());
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int               r;
		int               len;
		int               win;
		logic [SEQ_W-1:0] base;

		live_st = '0;
		live_st.win = WIN_RESET;
		gen_st = live_st;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// link down: everything but connect is dropped
		push_packet(OP_DATA, 4'd3);
		push_packet(OP_ACK, 4'd0);
		push_packet(OP_FINISH, 4'd0);
		push_packet(OP_OTHER, 4'd7);
		// connect at the top of the space wraps the expected number to zero
		push_packet(OP_CONNECT, 4'd15);
		push_packet(OP_CONNECT, 4'd4);
		// buffer ahead, edge of window, then fill the hole
		push_packet(OP_DATA, 4'd2);
		push_packet(OP_DATA, 4'd4);
		push_packet(OP_DATA, 4'd5);
		push_packet(OP_DATA, 4'd1);
		push_packet(OP_DATA, 4'd0);
		push_packet(OP_DATA, 4'd3);
		push_packet(OP_DATA, 4'd0);
		push_packet(OP_OTHER, 4'd15);
		push_packet(OP_ACK, 4'd9);
		// close: finish, ack with the wrong number, in-order finish, matching ack
		push_packet(OP_FINISH, 4'd6);
		push_packet(OP_ACK, 4'd6);
		push_packet(OP_FINISH, 4'd5);
		push_packet(OP_ACK, 4'd7);
		push_packet(OP_CONNECT, 4'd7);
		push_packet(OP_FINISH, 4'd8);
		push_packet(OP_ACK, 4'd9);
		// buffered run across the wrap point
		push_packet(OP_CONNECT, 4'd13);
		push_packet(OP_DATA, 4'd0);
		push_packet(OP_DATA, 4'd15);
		push_packet(OP_DATA, 4'd14);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_drained();
				win = (win_plan[ph] != 0) ? win_plan[ph] : $urandom_range(1, 15);
				@(posedge clk);
				cfg_we <= 1'b1;
				cfg_wdata <= WIN_W'(win);
				@(posedge clk);
				cfg_we <= 1'b0;
				live_st.win = WIN_W'(win);
				gen_st.win = WIN_W'(win);
				settings_n++;
			end
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase

			// widest window: buffer all slots ahead but the last, then drain them in order
			if (gen_st.win == WIN_MAX) begin
				if (!gen_st.link) push_packet(OP_CONNECT, SEQ_W'($urandom_range(0, 15)));
				base = gen_st.next_seq;
				for (int k = 1; k < SEQ_SPACE; k++) push_packet(OP_DATA, base + SEQ_W'(k));
				push_packet(OP_DATA, base);
			end

			queued_effective = 0;
			while (queued_effective < PACKETS_PER_PHASE) begin
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(1, 6))
						push_packet(OP_W'($urandom_range(0, 4)), SEQ_W'($urandom_range(0, 15)));
				end else begin
					len = $urandom_range(3, 30);
					repeat (len) begin
						r = $urandom_range(99);
						if (!gen_st.link)
							push_packet(OP_CONNECT, SEQ_W'($urandom_range(0, 15)));
						else if (r < 35)
							push_packet(OP_DATA,
								SEQ_W'(gen_st.next_seq + $urandom_range(0, gen_st.win - 1)));
						else if (r < 55)
							push_packet(OP_DATA, gen_st.next_seq);
						else if (r < 65)
							push_packet(OP_DATA, SEQ_W'($urandom_range(0, 15)));
						else if (r < 72)
							push_packet(OP_ACK, SEQ_W'($urandom_range(0, 15)));
						else if (r < 78)
							push_packet(OP_OTHER, SEQ_W'($urandom_range(0, 15)));
						else if (r < 83)
							push_packet(OP_CONNECT, SEQ_W'($urandom_range(0, 15)));
						else if (r < 88)
							push_packet(OP_FINISH,
								SEQ_W'(gen_st.next_seq + $urandom_range(0, gen_st.win - 1)));
						else
							push_packet(OP_DATA, SEQ_W'(gen_st.next_seq - $urandom_range(1, 4)));
					end
					// orderly teardown for most sessions
					if (gen_st.link) begin
						push_packet(OP_FINISH, gen_st.next_seq);
						if ($urandom_range(1))
							push_packet(OP_ACK, SEQ_W'(gen_st.next_seq + $urandom_range(1, 15)));
						if ($urandom_range(3) != 0) push_packet(OP_ACK, gen_st.next_seq);
					end
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d packets through %0d window settings, %0d results checked, %0d carried an ack",
			packets_taken, settings_n, results_seen, acks_seen);
		$display("idle mixes: none, sender gaps, receiver stalls, both; %0d mismatches",
			mismatch_n);
		if (mismatch_n == 0 && acks_due.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

// ----- selective_repeat_receive_window.f -----
src/srrw_pkg.sv
src/srrw_ctrl.sv
src/srrw_dp.sv
src/selective_repeat_receive_window.sv
bench/selective_repeat_receive_window_tb.sv
